FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pors_pkg.sv
// ----------------------------------------------------------------------------
// pors_pkg
// shared types and codes of the preference-oriented rm scheduler
// ----------------------------------------------------------------------------
package pors_pkg;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    // input transaction payload
    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  task_slot;
        logic [15:0] period;
        logic [15:0] exec_time;
        logic        prefers_late;
    } t_in;

    // result transaction payload
    typedef struct packed {
        logic        ran_task;
        logic [3:0]  running_slot;
        logic [15:0] missed_mask;
        logic [31:0] tick_time;
    } t_out;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SO_RD,
        ST_SO_LAT,
        ST_SJ_RD,
        ST_SJ_LAT,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_SWR,
        ST_EMIT_PLAIN,
        ST_T_SCAN,
        ST_T_UPD,
        ST_EMIT_TICK
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic cap;
        logic load_we;
        logic latch_i;
        logic live;
        logic latch_j;
        logic div_start;
        logic mul_ld;
        logic acc;
        logic promo_we;
        logic time_clr;
        logic scan_clr;
        logic iss1;
        logic iss2;
        logic emit_plain;
        logic emit_tick;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic late_i;
        logic qual;
        logic div_done;
        logic pv;
    } t_dp_sts;

endpackage

FILE: rtl/pors_ram.sv
// ----------------------------------------------------------------------------
// pors_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module pors_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pors_div.sv
// ----------------------------------------------------------------------------
// pors_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pors_div #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic         o_rem_nz
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_dvs;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [W:0]      sh;
    logic [W:0]      diff;
    logic            ge;

    // one trial subtraction
    assign sh   = {r_rem, r_quo[W-1]};
    assign diff = sh - {1'b0, r_dvs};
    assign ge   = sh >= {1'b0, r_dvs};

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= ge ? diff[W-1:0] : sh[W-1:0];
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNTW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_quo;
    assign o_rem_nz = r_rem != '0;

    // assertions
    `ASSERT_NEXT(a_div_start_busy, i_clk, i_rst_n, i_start, r_busy, "divider not busy after start")
    `ASSERT_SAME(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")

endmodule

FILE: rtl/pors_ctrl.sv
// ----------------------------------------------------------------------------
// pors_ctrl
// sequencer of the scheduler: load, promotion pass and tick walks
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pors_ctrl #(
    parameter int MAX_TASKS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [1:0]                   i_cmd,
    input  logic                         i_cfg_we,
    input  logic [4:0]                   i_cfg_wdata,
    input  pors_pkg::t_dp_sts            i_sts,
    output pors_pkg::t_dp_cmd            o_cmd,
    output logic [$clog2(MAX_TASKS)-1:0] o_addr,
    output logic                         busy
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    pors_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [4:0]        r_active;
    logic [CW-1:0]     n_live;
    pors_pkg::t_dp_cmd cmd;
    logic [AW-1:0]     addr;

    // active task count, clamped to the table size
    assign n_live = (32'(r_active) > 32'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(r_active);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pors_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        cmd     = '0;
        addr    = r_i[AW-1:0];
        unique case (r_state)
            pors_pkg::ST_IDLE: begin
                if (start) begin
                    cmd.cap = 1'b1;
                    unique case (pors_pkg::t_cmd'(i_cmd))
                        pors_pkg::CMD_LOAD: begin
                            n_state = pors_pkg::ST_LOAD;
                        end
                        pors_pkg::CMD_START: begin
                            cmd.time_clr = 1'b1;
                            n_i          = '0;
                            n_state      = pors_pkg::ST_SO_RD;
                        end
                        pors_pkg::CMD_TICK: begin
                            cmd.scan_clr = 1'b1;
                            n_j          = '0;
                            n_state      = pors_pkg::ST_T_SCAN;
                        end
                        default: begin
                            cmd.emit_plain = 1'b1;
                        end
                    endcase
                end
            end
            pors_pkg::ST_LOAD: begin
                cmd.load_we    = 1'b1;
                cmd.emit_plain = 1'b1;
                n_state        = pors_pkg::ST_IDLE;
            end
            pors_pkg::ST_SO_RD: begin
                n_state = pors_pkg::ST_SO_LAT;
            end
            pors_pkg::ST_SO_LAT: begin
                cmd.latch_i = 1'b1;
                cmd.live    = r_i < n_live;
                if ((r_i < n_live) && i_sts.late_i) begin
                    n_j     = '0;
                    n_state = pors_pkg::ST_SJ_RD;
                end else begin
                    n_state = pors_pkg::ST_SWR;
                end
            end
            pors_pkg::ST_SJ_RD: begin
                addr = r_j[AW-1:0];
                if (r_j >= n_live) begin
                    n_state = pors_pkg::ST_SWR;
                end else begin
                    n_state = pors_pkg::ST_SJ_LAT;
                end
            end
            pors_pkg::ST_SJ_LAT: begin
                cmd.latch_j = 1'b1;
                if (i_sts.qual && (r_j != r_i)) begin
                    cmd.div_start = 1'b1;
                    n_state       = pors_pkg::ST_DIV;
                end else begin
                    n_j     = r_j + CW'(1);
                    n_state = pors_pkg::ST_SJ_RD;
                end
            end
            pors_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = pors_pkg::ST_MUL;
                end
            end
            pors_pkg::ST_MUL: begin
                cmd.mul_ld = 1'b1;
                n_state    = pors_pkg::ST_ACC;
            end
            pors_pkg::ST_ACC: begin
                cmd.acc = 1'b1;
                n_j     = r_j + CW'(1);
                n_state = pors_pkg::ST_SJ_RD;
            end
            pors_pkg::ST_SWR: begin
                cmd.promo_we = 1'b1;
                n_i          = r_i + CW'(1);
                if (r_i == CW'(MAX_TASKS - 1)) begin
                    n_state = pors_pkg::ST_EMIT_PLAIN;
                end else begin
                    n_state = pors_pkg::ST_SO_RD;
                end
            end
            pors_pkg::ST_EMIT_PLAIN: begin
                cmd.emit_plain = 1'b1;
                n_state        = pors_pkg::ST_IDLE;
            end
            pors_pkg::ST_T_SCAN: begin
                addr = r_j[AW-1:0];
                if (r_j < n_live) begin
                    cmd.iss1 = 1'b1;
                    n_j      = r_j + CW'(1);
                end else if (!i_sts.pv) begin
                    n_j     = '0;
                    n_state = pors_pkg::ST_T_UPD;
                end
            end
            pors_pkg::ST_T_UPD: begin
                addr = r_j[AW-1:0];
                if (r_j < n_live) begin
                    cmd.iss2 = 1'b1;
                    n_j      = r_j + CW'(1);
                end else if (!i_sts.pv) begin
                    n_state = pors_pkg::ST_EMIT_TICK;
                end
            end
            pors_pkg::ST_EMIT_TICK: begin
                cmd.emit_tick = 1'b1;
                n_state       = pors_pkg::ST_IDLE;
            end
            default: begin
                n_state = pors_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_addr = addr;
    assign busy   = r_state != pors_pkg::ST_IDLE;

    // assertions
    `ASSERT_NEXT(a_tick_scan, i_clk, i_rst_n, start && !busy && (i_cmd == pors_pkg::CMD_TICK), r_state == pors_pkg::ST_T_SCAN, "tick did not enter scan")
    `ASSERT_NEXT(a_div_wait, i_clk, i_rst_n, cmd.div_start, r_state == pors_pkg::ST_DIV, "divider start without wait")

endmodule

FILE: rtl/pors_dp.sv
// ----------------------------------------------------------------------------
// pors_dp
// task tables, promotion arithmetic, tick selection and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pors_dp #(
    parameter int MAX_TASKS  = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pors_pkg::t_in                i_item,
    input  pors_pkg::t_dp_cmd            i_cmd,
    input  logic [$clog2(MAX_TASKS)-1:0] i_addr,
    output pors_pkg::t_dp_sts            o_sts,
    output logic                         o_strobe,
    output pors_pkg::t_out               o_result
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int TW = TIME_WIDTH;
    localparam int SW = 2 * TW + 1;
    localparam int DW = 3 * TW;

    pors_pkg::t_in  r_item;
    pors_pkg::t_out r_out;
    logic           r_strobe;
    logic [31:0]    r_time;

    // static table: late, exec, period
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [SW-1:0] st_wdata;
    logic [SW-1:0] st_rd;
    logic [TW-1:0] st_per;
    logic [TW-1:0] st_ex;
    logic          st_late;
    logic [31:0]   slot_ext;
    logic [31:0]   per_ext;
    logic [31:0]   ex_ext;

    // dynamic table: promotion, remaining, phase
    logic                 dy_we;
    logic [AW-1:0]        dy_waddr;
    logic [DW-1:0]        dy_wdata;
    logic [DW-1:0]        dy_rd;
    logic [DW-1:0]        dy;
    logic [TW-1:0]        dy_promo;
    logic [TW-1:0]        dy_rem;
    logic [TW-1:0]        dy_phase;
    logic [MAX_TASKS-1:0] r_dvalid;
    logic                 r_dvq;

    // promotion arithmetic
    logic [TW-1:0]   r_pi;
    logic [TW-1:0]   r_ei;
    logic [TW-1:0]   r_ej;
    logic [TW-1:0]   r_resp;
    logic            r_skip;
    logic [2*TW-1:0] r_prod;
    logic            div_done;
    logic [TW-1:0]   div_quot;
    logic            div_rem_nz;
    logic [TW-1:0]   ceilq;
    logic [TW-1:0]   term;
    logic [TW:0]     sum;
    logic [TW-1:0]   promo_val;

    // tick walk
    logic          r_pv;
    logic          r_pass2;
    logic [AW-1:0] r_pidx;
    logic          r_found;
    logic [AW-1:0] r_best;
    logic [TW-1:0] r_bestper;
    logic [15:0]   r_missed;
    logic          elig;
    logic          is_best;
    logic [TW-1:0] rem1;
    logic [TW:0]   nxt;
    logic          wrap;
    logic [31:0]   pidx_ext;
    logic [31:0]   best_ext;

    // captured item, held through the transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_item <= i_item;
        end
    end

    // field widths folded to the time width
    assign slot_ext = {28'b0, r_item.task_slot};
    assign per_ext  = {16'b0, r_item.period};
    assign ex_ext   = {16'b0, r_item.exec_time};
    assign st_we    = i_cmd.load_we && (slot_ext < 32'(MAX_TASKS));
    assign st_waddr = slot_ext[AW-1:0];
    assign st_wdata = {r_item.prefers_late, ex_ext[TW-1:0], per_ext[TW-1:0]};

    pors_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_TASKS)
    ) u_static (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(i_addr),
        .o_rdata(st_rd)
    );

    assign st_per  = st_rd[TW-1:0];
    assign st_ex   = st_rd[2*TW-1:TW];
    assign st_late = st_rd[2*TW];

    pors_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_TASKS)
    ) u_dynamic (
        .i_clk  (i_clk),
        .i_we   (dy_we),
        .i_waddr(dy_waddr),
        .i_wdata(dy_wdata),
        .i_raddr(i_addr),
        .o_rdata(dy_rd)
    );

    // entries never written read as zero
    assign dy       = r_dvq ? dy_rd : '0;
    assign dy_phase = dy[TW-1:0];
    assign dy_rem   = dy[2*TW-1:TW];
    assign dy_promo = dy[3*TW-1:2*TW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
            r_dvq    <= 1'b0;
        end else begin
            r_dvq <= r_dvalid[i_addr];
            if (dy_we) begin
                r_dvalid[dy_waddr] <= 1'b1;
            end
        end
    end

    // divider for ceil(own period / other period)
    pors_div #(
        .W(TW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(r_pi),
        .i_divisor ((st_per == '0) ? TW'(1) : st_per),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_rem_nz  (div_rem_nz)
    );

    assign ceilq     = div_quot + TW'(div_rem_nz);
    assign term      = (r_prod > (2*TW)'(r_pi)) ? r_pi : r_prod[TW-1:0];
    assign sum       = {1'b0, r_resp} + {1'b0, term};
    assign promo_val = r_skip ? '0 : (r_pi - r_resp);

    // response time accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_i) begin
            r_pi   <= st_per;
            r_ei   <= st_ex;
            r_resp <= (st_ex > st_per) ? st_per : st_ex;
            r_skip <= !(i_cmd.live && st_late);
        end
        if (i_cmd.latch_j) begin
            r_ej <= st_ex;
        end
        if (i_cmd.mul_ld) begin
            r_prod <= (2*TW)'(ceilq) * (2*TW)'(r_ej);
        end
        if (i_cmd.acc) begin
            r_resp <= (sum > {1'b0, r_pi}) ? r_pi : sum[TW-1:0];
        end
    end

    // tick walk pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_pass2 <= 1'b0;
        end else begin
            r_pv    <= i_cmd.iss1 || i_cmd.iss2;
            r_pass2 <= i_cmd.iss2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= i_addr;
    end

    assign elig     = (dy_phase >= dy_promo) && (dy_rem != '0);
    assign is_best  = r_found && (r_pidx == r_best);
    assign rem1     = is_best ? (dy_rem - TW'(1)) : dy_rem;
    assign nxt      = {1'b0, dy_phase} + (TW+1)'(1);
    assign wrap     = (nxt >= {1'b0, st_per}) || (nxt[TW-1:0] == '0);
    assign pidx_ext = {{(32-AW){1'b0}}, r_pidx};
    assign best_ext = {{(32-AW){1'b0}}, r_best};

    // best candidate and missed deadlines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_best   <= '0;
            r_missed <= '0;
        end else if (i_cmd.scan_clr) begin
            r_found  <= 1'b0;
            r_best   <= '0;
            r_missed <= '0;
        end else if (r_pv && !r_pass2) begin
            if (elig && (!r_found || (st_per < r_bestper))) begin
                r_found <= 1'b1;
                r_best  <= r_pidx;
            end
        end else if (r_pv && r_pass2) begin
            if (wrap && (rem1 != '0) && (pidx_ext < 32'd16)) begin
                r_missed <= r_missed | (16'(1) << pidx_ext[3:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pv && !r_pass2 && elig && (!r_found || (st_per < r_bestper))) begin
            r_bestper <= st_per;
        end
    end

    // dynamic table write port
    assign dy_we    = i_cmd.promo_we || (r_pv && r_pass2);
    assign dy_waddr = (r_pv && r_pass2) ? r_pidx : i_addr;
    always_comb begin
        if (r_pv && r_pass2) begin
            if (wrap) begin
                dy_wdata = {dy_promo, st_ex, {TW{1'b0}}};
            end else begin
                dy_wdata = {dy_promo, rem1, nxt[TW-1:0]};
            end
        end else begin
            dy_wdata = {promo_val, r_ei, {TW{1'b0}}};
        end
    end

    // tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_cmd.time_clr) begin
            r_time <= '0;
        end else if (i_cmd.emit_tick) begin
            r_time <= r_time + 32'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_plain || i_cmd.emit_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_tick) begin
            r_out.ran_task     <= r_found;
            r_out.running_slot <= best_ext[3:0];
            r_out.missed_mask  <= r_missed;
            r_out.tick_time    <= r_time;
        end else if (i_cmd.emit_plain) begin
            r_out.ran_task     <= 1'b0;
            r_out.running_slot <= '0;
            r_out.missed_mask  <= '0;
            r_out.tick_time    <= r_time;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_result       = r_out;
    assign o_sts.late_i   = st_late;
    assign o_sts.qual     = st_late && (st_per < r_pi);
    assign o_sts.div_done = div_done;
    assign o_sts.pv       = r_pv;

    // assertions
    `ASSERT_NEXT(a_plain_clean, i_clk, i_rst_n, i_cmd.emit_plain, (r_out.missed_mask == '0) && !r_out.ran_task, "non-tick result carries tick data")
    `ASSERT_SAME(a_one_dy_writer, i_clk, i_rst_n, i_cmd.promo_we, !(r_pv && r_pass2), "two writers on dynamic table")

endmodule

FILE: rtl/pref_oriented_rm_scheduler.sv
// ----------------------------------------------------------------------------
// pref_oriented_rm_scheduler
// tick-driven preference-oriented rate-monotonic scheduler
// ----------------------------------------------------------------------------
// usage: a transaction is taken when start is high and busy is low; i_item
// carries a load, start or tick command. every transaction gives exactly one
// result on o_result, shown for one cycle with o_strobe; the receiver cannot
// stall, so it must take each result as it comes.
// i_cfg_we / i_cfg_wdata write the active task count; the user must write it
// only while the block is idle; the block itself does not enforce this.
// work behind each command:
//   load or unused command: no table walk
//   tick: two walks over the n active task entries, one entry per cycle
//     through the single read port of each table ram
//   start: a walk over all MAX_TASKS entries, plus a walk over the n active
//     tasks for each active late task, plus a division in the shared
//     bit-serial divider for every shorter-period late pair
// a new transaction is taken the cycle the result strobe is shown.
// after reset the time, phases, work and promotions read as zero and the
// task count is zero; period and execution entries hold nothing until loaded.
// ----------------------------------------------------------------------------
module pref_oriented_rm_scheduler #(
    parameter int MAX_TASKS  = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  pors_pkg::t_in   i_item,
    output logic            busy,
    output logic            o_strobe,
    output pors_pkg::t_out  o_result,
    input  logic            i_cfg_we,
    input  logic [4:0]      i_cfg_wdata
);

    pors_pkg::t_dp_cmd            cmd;
    pors_pkg::t_dp_sts            sts;
    logic [$clog2(MAX_TASKS)-1:0] addr;

    // sequencer
    pors_ctrl #(
        .MAX_TASKS(MAX_TASKS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_item.cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_addr     (addr),
        .busy       (busy)
    );

    // tables and arithmetic
    pors_dp #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_WIDTH(TIME_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .o_sts   (sts),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the preference-oriented rm scheduler: a behavioural
// predictor in a scoreboard works out every result from the accepted
// transactions, and the results are checked field by field in order
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          NUM_SLOTS   = 16;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 1_500_000;

    // scheduler predictor and store of expected results
    class sched_scoreboard;
        logic [15:0] period_tab [NUM_SLOTS];
        logic [15:0] exec_tab   [NUM_SLOTS];
        logic        late_tab   [NUM_SLOTS];
        logic [15:0] promo_tab  [NUM_SLOTS];
        logic [15:0] work_left  [NUM_SLOTS];
        logic [15:0] phase_tab  [NUM_SLOTS];
        logic [31:0] tick_count;
        logic [4:0]  active_cnt;
        pors_pkg::t_out expected_results [$];
        int          errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                promo_tab[i] = '0;
                work_left[i] = '0;
                phase_tab[i] = '0;
            end
            tick_count = '0;
            active_cnt = '0;
            errors     = 0;
        endfunction

        function int live_tasks();
            return (active_cnt > NUM_SLOTS) ? NUM_SLOTS : active_cnt;
        endfunction

        // promotion time = period - response time of each live late task
        function void compute_promotions();
            int n;
            longint unsigned p_own, p_oth, resp, term;
            n = live_tasks();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (i >= n || !late_tab[i]) begin
                    promo_tab[i] = '0;
                    continue;
                end
                p_own = period_tab[i];
                resp  = (exec_tab[i] > p_own) ? p_own : exec_tab[i];
                for (int j = 0; j < n; j++) begin
                    p_oth = period_tab[j];
                    if (j == i || !late_tab[j] || p_oth >= p_own)
                        continue;
                    if (p_oth == 0)
                        p_oth = 1;
                    term = ((p_own + p_oth - 1) / p_oth) * exec_tab[j];
                    if (term > p_own)
                        term = p_own;
                    resp += term;
                    if (resp > p_own)
                        resp = p_own;
                end
                promo_tab[i] = 16'(p_own - resp);
            end
        endfunction

        // work out the result of an accepted transaction
        function void note_item(pors_pkg::t_in it);
            pors_pkg::t_out r;
            int   n, best;
            bit   found;
            logic [16:0] nxt;
            r = '0;
            r.tick_time = tick_count;
            n = live_tasks();
            if (it.cmd == pors_pkg::CMD_LOAD) begin
                period_tab[it.task_slot] = it.period;
                exec_tab[it.task_slot]   = it.exec_time;
                late_tab[it.task_slot]   = it.prefers_late;
            end else if (it.cmd == pors_pkg::CMD_START) begin
                compute_promotions();
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    work_left[i] = exec_tab[i];
                    phase_tab[i] = '0;
                end
                tick_count  = '0;
                r.tick_time = '0;
            end else if (it.cmd == pors_pkg::CMD_TICK) begin
                found = 0;
                best  = 0;
                for (int i = 0; i < n; i++) begin
                    if (phase_tab[i] >= promo_tab[i] && work_left[i] != 0) begin
                        if (!found || period_tab[i] < period_tab[best]) begin
                            best  = i;
                            found = 1;
                        end
                    end
                end
                if (found) begin
                    work_left[best] = work_left[best] - 16'd1;
                    r.ran_task      = 1'b1;
                    r.running_slot  = 4'(best);
                end
                // phase advance, wrap and deadline miss
                for (int i = 0; i < n; i++) begin
                    nxt = {1'b0, phase_tab[i]} + 17'd1;
                    if (nxt >= {1'b0, period_tab[i]} || nxt[15:0] == 0) begin
                        if (work_left[i] != 0)
                            r.missed_mask[i] = 1'b1;
                        work_left[i] = exec_tab[i];
                        phase_tab[i] = '0;
                    end else begin
                        phase_tab[i] = nxt[15:0];
                    end
                end
                tick_count = tick_count + 32'd1;
            end
            expected_results.push_back(r);
        endfunction

        // compare a result with the oldest expectation
        function void check_result(pors_pkg::t_out got);
            pors_pkg::t_out exp_r;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %p", got);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.ran_task !== exp_r.ran_task) begin
                $error("ran_task exp %0d got %0d", exp_r.ran_task, got.ran_task);
                errors++;
            end
            if (got.running_slot !== exp_r.running_slot) begin
                $error("running_slot exp %0d got %0d", exp_r.running_slot,
                       got.running_slot);
                errors++;
            end
            if (got.missed_mask !== exp_r.missed_mask) begin
                $error("missed_mask exp %h got %h", exp_r.missed_mask, got.missed_mask);
                errors++;
            end
            if (got.tick_time !== exp_r.tick_time) begin
                $error("tick_time exp %0d got %0d", exp_r.tick_time, got.tick_time);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    pors_pkg::t_in  i_item = '0;
    logic           busy;
    logic           o_strobe;
    pors_pkg::t_out o_result;
    logic           i_cfg_we = 1'b0;
    logic [4:0]     i_cfg_wdata = '0;

    sched_scoreboard sb = new();
    int          burst_left = 0;
    int          cycles = 0;

    pref_oriented_rm_scheduler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (i_item),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_result);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // send one transaction, idling in bursts with random gaps
    task automatic send_item(pors_pkg::t_in it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                             : $urandom_range(1, 5))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_cmd(logic [1:0] c, logic [3:0] slot, logic [15:0] per,
                            logic [15:0] ex, logic lt);
        pors_pkg::t_in it;
        it.cmd = c;
        it.task_slot = slot;
        it.period = per;
        it.exec_time = ex;
        it.prefers_late = lt;
        send_item(it);
    endtask

    // random task entry, mostly short periods so that wraps and misses occur
    task automatic load_random(logic [3:0] slot);
        logic [15:0] per, ex;
        int sel;
        sel = $urandom_range(0, 19);
        per = (sel == 0) ? 16'd0 : (sel < 3) ? 16'($urandom) : 16'($urandom_range(1, 24));
        ex  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        send_cmd(pors_pkg::CMD_LOAD, slot, per, ex, 1'($urandom));
    endtask

    // let the block go idle, then write the task count
    task automatic set_active(logic [4:0] cnt);
        if (start)
            start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.active_cnt = cnt;
        burst_left = 0;
    endtask

    initial begin
        int n_items;
        logic [4:0] cnt_choice [12];

        cnt_choice = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd1, 5'd17,
                       5'd5, 5'd16, 5'd3, 5'd8, 5'd12, 5'd16};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of every field, every command
        set_active(5'd16);
        send_cmd(pors_pkg::CMD_LOAD, 4'd0, 16'd0, 16'd1, 1'b1);
        send_cmd(pors_pkg::CMD_LOAD, 4'd1, 16'd1, 16'd0, 1'b0);
        send_cmd(pors_pkg::CMD_LOAD, 4'd2, 16'd4, 16'd65535, 1'b1);
        send_cmd(pors_pkg::CMD_LOAD, 4'd3, 16'd65535, 16'd65535, 1'b1);
        send_cmd(pors_pkg::CMD_LOAD, 4'd4, 16'd6, 16'd2, 1'b1);
        for (int s = 5; s < NUM_SLOTS - 1; s++)
            send_cmd(pors_pkg::CMD_LOAD, 4'(s), 16'(3 + s), 16'(s % 3), 1'(s));
        send_cmd(pors_pkg::CMD_LOAD, 4'd15, 16'd65535, 16'd65535, 1'b1);
        send_cmd(pors_pkg::CMD_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
        send_cmd(CMD_UNUSED, 4'hf, 16'hffff, 16'hffff, 1'b1);
        send_cmd(pors_pkg::CMD_START, 4'd0, 16'd0, 16'd0, 1'b0);
        repeat (6) send_cmd(pors_pkg::CMD_TICK, 4'hf, 16'hffff, 16'hffff, 1'b1);

        // random phases over several task counts
        n_items = 0;
        foreach (cnt_choice[p]) begin
            set_active(cnt_choice[p]);
            repeat ($urandom_range(3, 10))
                load_random(4'($urandom));
            send_cmd(pors_pkg::CMD_START, 4'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom));
            repeat (100) begin
                case ($urandom_range(0, 39))
                    0: load_random(4'($urandom));
                    1: send_cmd(CMD_UNUSED, 4'($urandom), 16'($urandom),
                                16'($urandom), 1'($urandom));
                    2: send_cmd(pors_pkg::CMD_START, 4'($urandom), 16'($urandom),
                                16'($urandom), 1'($urandom));
                    default: send_cmd(pors_pkg::CMD_TICK, 4'($urandom), 16'($urandom),
                                      16'($urandom), 1'($urandom));
                endcase
                n_items++;
            end
        end

        // drain and finish
        if (start)
            start <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
